>>> sv/edf_pkg.sv
// Shared types and constants for the earliest-deadline-first job scheduler.
// Used by edf_queue and preemptive_edf_job_scheduler; depends on nothing.
`default_nettype none

package edf_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int SERIAL_BITS = 16;
   localparam int TIME_BITS   = 32;
   localparam int WORK_BITS   = 16;
   localparam int CLASS_BITS  = 2;
   localparam int QIDX_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int SCAN_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Result kinds
   localparam logic [1:0] EV_RECEIVED = 2'd0;
   localparam logic [1:0] EV_FINISHED = 2'd1;
   localparam logic [1:0] EV_DROPPED  = 2'd2;

   localparam logic [CLASS_BITS-1:0] CLASS_TOP = 2'd2;

   // Request kinds
   localparam logic REQ_ARRIVAL = 1'b0;
   localparam logic REQ_TICK    = 1'b1;

   // Register indexes; the two spare indexes are ignored on write
   typedef enum logic [2:0] {
      CSR_SERVICE0, CSR_SERVICE1, CSR_SERVICE2,
      CSR_DEADLINE0, CSR_DEADLINE1, CSR_DEADLINE2,
      CSR_SPARE6, CSR_SPARE7
   } csr_index_type;

   // One job, running or waiting in the queue
   typedef struct packed {
      logic [TIME_BITS-1:0]   deadline;
      logic [TIME_BITS-1:0]   arrival;
      logic [WORK_BITS-1:0]   remaining;
      logic [SERIAL_BITS-1:0] serial;
      logic [CLASS_BITS-1:0]  cls;
      logic                   started;
   } edf_job_type;

   // Queue controls from the sequencer
   typedef struct packed {
      logic                 wr_en;
      logic [QIDX_BITS-1:0] wr_addr;
      logic                 rd_en;
      logic [QIDX_BITS-1:0] rd_addr;
      logic                 clr_en;
      logic [QIDX_BITS-1:0] clr_addr;
   } edf_qctl_type;

   // Queue status back to the sequencer
   typedef struct packed {
      logic                 free_found;
      logic [QIDX_BITS-1:0] free_idx;
      logic                 rd_valid;
   } edf_qstat_type;

   // True if arrival stamp a came before b, wrap-aware
   function automatic logic arrived_before(input logic [TIME_BITS-1:0] a,
                                           input logic [TIME_BITS-1:0] b);
      logic [TIME_BITS-1:0] diff;
      diff = a - b;
      return diff[TIME_BITS-1];
   endfunction

endpackage

`default_nettype wire

>>> sv/edf_queue.sv
// Job queue: entry memory with one write and one registered read port,
// per-entry valid bits and a lowest-free-slot search. Depends on edf_pkg.
`default_nettype none

module edf_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  edf_pkg::edf_qctl_type  qctl,
   input  edf_pkg::edf_job_type   wr_job,
   output edf_pkg::edf_qstat_type qstat,
   output edf_pkg::edf_job_type   rd_job
);
   import edf_pkg::*;

   edf_job_type            mem [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] valid_ff;
   edf_job_type            rd_job_ff;
   logic                   rd_valid_ff;
   logic                   free_found;
   logic [QIDX_BITS-1:0]   free_idx;

   always_ff @(posedge clock) begin
      if (qctl.wr_en) begin
         mem[qctl.wr_addr] <= wr_job;
      end
      if (qctl.rd_en) begin
         rd_job_ff   <= mem[qctl.rd_addr];
         rd_valid_ff <= valid_ff[qctl.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (qctl.wr_en) begin
            valid_ff[qctl.wr_addr] <= 1'b1;
         end
         if (qctl.clr_en) begin
            valid_ff[qctl.clr_addr] <= 1'b0;
         end
      end
   end

   // Lowest free slot wins
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = QIDX_BITS'(i);
         end
      end
   end

   assign qstat.free_found = free_found;
   assign qstat.free_idx   = free_idx;
   assign qstat.rd_valid   = rd_valid_ff;
   assign rd_job           = rd_job_ff;

endmodule

`default_nettype wire

>>> sv/preemptive_edf_job_scheduler.sv
// Preemptive earliest-deadline-first scheduler for three job classes.
// Top level: sequencer, running job, class registers. Depends on edf_pkg, edf_queue.
//
//   channel   direction  handshake               transaction carries
//   req_      in         start & !busy            req_type, req_job_class
//   rsp_      out        rsp_valid (one cycle)    kind, class, serial, last
//   csr_      in         csr_valid & csr_ready    csr_index, csr_data
//
// An arrival passes through ARRIVE and DECIDE, a tick through TICK; when the running
// job completes, the tick goes on through SCAN and FINISH (and RECV when a first start
// is reported): the earliest-deadline search reads the queue memory one entry a cycle
// through its single read port. Results leave one a cycle and cannot be stalled. Reset
// is synchronous; no clearing pass is needed since the queue entries carry valid bits.
`default_nettype none

module preemptive_edf_job_scheduler (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire         req_type,
   input  wire  [1:0]  req_job_class,
   output logic        rsp_valid,
   output logic [1:0]  rsp_event_kind,
   output logic [1:0]  rsp_event_class,
   output logic [15:0] rsp_event_serial,
   output logic        rsp_last,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [2:0]  csr_index,
   input  wire  [15:0] csr_data
);
   import edf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ARRIVE, ST_DECIDE, ST_TICK, ST_SCAN, ST_FINISH, ST_RECV
   } state_type;

   state_type              state_ff;
   logic [WORK_BITS-1:0]   svc_ff [3];
   logic [15:0]            dl_ff  [3];
   logic [TIME_BITS-1:0]   now_ff;
   logic [TIME_BITS-1:0]   arrival_ff;
   logic [SERIAL_BITS-1:0] next_serial_ff [3];
   logic                   run_valid_ff;
   edf_job_type            run_ff;
   edf_job_type            new_ff;
   logic [CLASS_BITS-1:0]  class_ff;
   logic [SCAN_BITS-1:0]   scan_ff;
   logic                   best_found_ff;
   logic [QIDX_BITS-1:0]   best_idx_ff;
   edf_job_type            best_ff;

   logic                   rsp_valid_ff;
   logic [1:0]             rsp_kind_ff;
   logic [1:0]             rsp_class_ff;
   logic [15:0]            rsp_serial_ff;
   logic                   rsp_last_ff;

   edf_qctl_type           qctl;
   edf_qstat_type          qstat;
   edf_job_type            q_wr_job;
   edf_job_type            q_rd_job;
   logic                   preempt;
   logic                   better;
   logic [QIDX_BITS-1:0]   cand_idx;

   edf_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .qctl   (qctl),
      .wr_job (q_wr_job),
      .qstat  (qstat),
      .rd_job (q_rd_job)
   );

   assign preempt  = new_ff.deadline < run_ff.deadline;
   assign cand_idx = QIDX_BITS'(scan_ff - SCAN_BITS'(1));
   assign better   = qstat.rd_valid &&
                     (!best_found_ff || (q_rd_job.deadline < best_ff.deadline) ||
                      ((q_rd_job.deadline == best_ff.deadline) &&
                       arrived_before(q_rd_job.arrival, best_ff.arrival)));

   always_comb begin
      qctl          = '0;
      qctl.wr_en    = (state_ff == ST_DECIDE) && run_valid_ff && qstat.free_found;
      qctl.wr_addr  = qstat.free_idx;
      qctl.rd_en    = (state_ff == ST_SCAN) && (scan_ff < SCAN_BITS'(QUEUE_DEPTH));
      qctl.rd_addr  = QIDX_BITS'(scan_ff);
      qctl.clr_en   = (state_ff == ST_FINISH) && best_found_ff;
      qctl.clr_addr = best_idx_ff;
      // A preempted running job goes back to the queue, else the newcomer waits
      q_wr_job      = preempt ? run_ff : new_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         svc_ff[0] <= 16'd500;
         svc_ff[1] <= 16'd1000;
         svc_ff[2] <= 16'd200;
         dl_ff[0]  <= 16'd2000;
         dl_ff[1]  <= 16'd3000;
         dl_ff[2]  <= 16'd300;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SERVICE0:  svc_ff[0] <= csr_data;
            CSR_SERVICE1:  svc_ff[1] <= csr_data;
            CSR_SERVICE2:  svc_ff[2] <= csr_data;
            CSR_DEADLINE0: dl_ff[0]  <= csr_data;
            CSR_DEADLINE1: dl_ff[1]  <= csr_data;
            CSR_DEADLINE2: dl_ff[2]  <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rsp_valid_ff <= 1'b0;
      if (reset) begin
         state_ff       <= ST_IDLE;
         now_ff         <= '0;
         arrival_ff     <= '0;
         run_valid_ff   <= 1'b0;
         best_found_ff  <= 1'b0;
         scan_ff        <= '0;
         for (int i = 0; i < 3; i++) begin
            next_serial_ff[i] <= SERIAL_BITS'(1);
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  class_ff <= (req_job_class > CLASS_TOP) ? CLASS_TOP : req_job_class;
                  state_ff <= (req_type == REQ_TICK) ? ST_TICK : ST_ARRIVE;
               end
            end
            ST_ARRIVE: begin
               new_ff.deadline  <= now_ff + TIME_BITS'(dl_ff[class_ff]);
               new_ff.arrival   <= arrival_ff;
               new_ff.remaining <= svc_ff[class_ff];
               new_ff.serial    <= next_serial_ff[class_ff];
               new_ff.cls       <= class_ff;
               new_ff.started   <= 1'b0;
               next_serial_ff[class_ff] <= next_serial_ff[class_ff] + SERIAL_BITS'(1);
               arrival_ff       <= arrival_ff + TIME_BITS'(1);
               state_ff         <= ST_DECIDE;
            end
            ST_DECIDE: begin
               rsp_class_ff  <= new_ff.cls;
               rsp_serial_ff <= 16'(new_ff.serial);
               rsp_last_ff   <= 1'b1;
               if (!run_valid_ff || (qstat.free_found && preempt)) begin
                  run_valid_ff   <= 1'b1;
                  run_ff         <= new_ff;
                  run_ff.started <= 1'b1;
                  rsp_valid_ff   <= 1'b1;
                  rsp_kind_ff    <= EV_RECEIVED;
               end else if (!qstat.free_found) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= EV_DROPPED;
               end
               state_ff <= ST_IDLE;
            end
            ST_TICK: begin
               now_ff   <= now_ff + TIME_BITS'(1);
               state_ff <= ST_IDLE;
               if (run_valid_ff) begin
                  if (run_ff.remaining <= WORK_BITS'(1)) begin
                     run_ff.remaining <= '0;
                     scan_ff          <= '0;
                     best_found_ff    <= 1'b0;
                     state_ff         <= ST_SCAN;
                  end else begin
                     run_ff.remaining <= run_ff.remaining - WORK_BITS'(1);
                  end
               end
            end
            ST_SCAN: begin
               // Compare the entry read in the previous cycle
               if ((scan_ff != '0) && better) begin
                  best_found_ff <= 1'b1;
                  best_idx_ff   <= cand_idx;
                  best_ff       <= q_rd_job;
               end
               scan_ff <= scan_ff + SCAN_BITS'(1);
               if (scan_ff == SCAN_BITS'(QUEUE_DEPTH)) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               rsp_valid_ff  <= 1'b1;
               rsp_kind_ff   <= EV_FINISHED;
               rsp_class_ff  <= run_ff.cls;
               rsp_serial_ff <= 16'(run_ff.serial);
               rsp_last_ff   <= !(best_found_ff && !best_ff.started);
               run_valid_ff  <= best_found_ff;
               state_ff      <= ST_IDLE;
               if (best_found_ff) begin
                  run_ff         <= best_ff;
                  run_ff.started <= 1'b1;
                  if (!best_ff.started) begin
                     state_ff <= ST_RECV;
                  end
               end
            end
            ST_RECV: begin
               rsp_valid_ff  <= 1'b1;
               rsp_kind_ff   <= EV_RECEIVED;
               rsp_class_ff  <= run_ff.cls;
               rsp_serial_ff <= 16'(run_ff.serial);
               rsp_last_ff   <= 1'b1;
               state_ff      <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = rsp_kind_ff;
   assign rsp_event_class  = rsp_class_ff;
   assign rsp_event_serial = rsp_serial_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

`default_nettype wire
